// ----- design/assert_macros.svh -----
// Assertion helpers for the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge while out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When pre holds at one edge, post must hold at the next edge.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/srb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package srb_pkg;

  // Ring size in bytes. The slot of an offset is its low bits, so this is a power of two.
  localparam int unsigned DEPTH   = 4096;
  localparam int          SLOT_W  = $clog2(DEPTH);
  localparam int          OFF_W   = 32;
  localparam int          LEN_W   = 13;
  localparam int          CNT_W   = 13;
  localparam int          DATA_W  = 8;
  localparam int unsigned LEN_SAT = 8191;
  // Largest length the result can ever report.
  localparam int unsigned LEN_CAP = (DEPTH < LEN_SAT) ? DEPTH : LEN_SAT;
  localparam int          Q_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_QUERY   = 2'd1,
    ACT_READ    = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PKT_DONE = 2'd1,
    ST_DROP     = 2'd2,
    ST_CLAMP    = 2'd3
  } status_t;

  typedef struct packed {
    action_t             action;
    logic [OFF_W-1:0]    stream_offset;
    logic [DATA_W-1:0]   data_byte;
    logic                packet_last;
    logic [CNT_W-1:0]    release_count;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0]    head_offset;
    logic [LEN_W-1:0]    contiguous_len;
    logic [DATA_W-1:0]   read_data;
    status_t             status;
  } out_item_t;

  // Decoded command handed from the front end to the engine.
  typedef struct packed {
    action_t             op;
    logic [OFF_W-1:0]    offset;
    logic [SLOT_W-1:0]   slot;
    logic [DATA_W-1:0]   data;
    logic                last;
    logic [CNT_W-1:0]    count;
  } cmd_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [OFF_W-1:0] off);
    return off[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/stream_reorder_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                         Beat contents
// input     in_valid / in_ready / in_data  action, stream_offset, data_byte,
//                                          packet_last, release_count
// result    out_valid / out_ready / out_data head_offset, contiguous_len,
//                                          read_data, status
//
// Every input beat yields exactly one result beat, in order.
// After reset the engine sweeps the byte ring once to clear its valid bits;
// input beats queue up but none executes during the sweep.
// Write and drop finish in S_EXEC, read adds S_RD_WAIT, and query passes S_Q_CHK and S_Q_WAIT
// once per byte the tail advances and again to find its end (S_Q_CHK alone when the window is full);
// release adds one S_REL step per released byte. The single port of the byte ring sets these steps.
// The front register and a two-entry command queue keep accepting beats while
// the engine works or its result waits for out_ready.
module stream_reorder_buffer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire srb_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output srb_pkg::out_item_t      out_data
);
  import srb_pkg::*;

  // Front end to queue.
  logic enq_valid;
  logic enq_ready;
  cmd_t enq_cmd;

  // Queue to engine.
  logic deq_valid;
  logic deq_pop;
  cmd_t deq_cmd;

  // The front end registers each beat and splits out its ring slot.
  srb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .enq_valid (enq_valid),
    .enq_ready (enq_ready),
    .enq_cmd   (enq_cmd)
  );

  // A short queue lets the front end run ahead of a long query or release.
  srb_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .enq_valid (enq_valid),
    .enq_ready (enq_ready),
    .enq_cmd   (enq_cmd),
    .deq_valid (deq_valid),
    .deq_pop   (deq_pop),
    .deq_cmd   (deq_cmd)
  );

  // The engine owns the byte ring, head and tail, and the result register.
  // Window checks are made here, against the head as it stands when the
  // command executes, since earlier releases may still be in flight.
  srb_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .deq_valid (deq_valid),
    .deq_pop   (deq_pop),
    .deq_cmd   (deq_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- design/srb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module srb_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire srb_pkg::in_item_t in_data,
  output logic                  enq_valid,
  input  wire logic             enq_ready,
  output srb_pkg::cmd_t         enq_cmd
);
  import srb_pkg::*;

  logic cmd_valid_r, cmd_valid_nxt;
  cmd_t cmd_r, cmd_nxt;
  logic take;

  // Holding register drains into the queue; a new beat may enter as the old one leaves.
  assign enq_valid = cmd_valid_r;
  assign enq_cmd   = cmd_r;
  assign in_ready  = !cmd_valid_r || enq_ready;
  assign take      = in_valid && in_ready;

  always_comb begin
    cmd_valid_nxt = take || (cmd_valid_r && !enq_ready);
    cmd_nxt       = cmd_r;
    if (take) begin
      cmd_nxt.op     = in_data.action;
      cmd_nxt.offset = in_data.stream_offset;
      cmd_nxt.slot   = slot_of(in_data.stream_offset);
      cmd_nxt.data   = in_data.data_byte;
      cmd_nxt.last   = in_data.packet_last;
      cmd_nxt.count  = in_data.release_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule
`default_nettype wire

// ----- design/srb_cmd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module srb_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          enq_valid,
  output logic               enq_ready,
  input  wire srb_pkg::cmd_t enq_cmd,
  output logic               deq_valid,
  input  wire logic          deq_pop,
  output srb_pkg::cmd_t      deq_cmd
);
  import srb_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_QW = $clog2(Q_DEPTH + 1);

  cmd_t              slot_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] fill_r, fill_nxt;
  logic              push, pop;

  assign enq_ready = (fill_r != CNT_QW'(Q_DEPTH));
  assign deq_valid = (fill_r != '0);
  assign deq_cmd   = slot_r[rd_ptr_r];
  assign push      = enq_valid && enq_ready;
  assign pop       = deq_pop && deq_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    fill_nxt = fill_r + CNT_QW'(push) - CNT_QW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= enq_cmd;
    end
  end

endmodule
`default_nettype wire

// ----- design/srb_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
module srb_engine (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              deq_valid,
  output logic                   deq_pop,
  input  wire srb_pkg::cmd_t     deq_cmd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output srb_pkg::out_item_t     out_data
);
  import srb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RD_WAIT, S_Q_CHK, S_Q_WAIT, S_REL
  } state_t;

  // Each entry holds the valid bit on top of the stored byte.
  logic [DATA_W:0]   byte_mem [DEPTH];
  logic [DATA_W:0]   mem_rd_r;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_addr;
  logic [DATA_W:0]   mem_wdata;

  state_t            state_r, state_nxt;
  logic [OFF_W-1:0]  head_r, head_nxt;
  logic [OFF_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic              clamp_r, clamp_nxt;
  cmd_t              cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              finish;
  status_t           res_status;
  logic [DATA_W-1:0] res_rdata;
  logic [OFF_W-1:0]  win_diff, avail, run_diff;
  logic              in_window, over;
  logic [CNT_W-1:0]  cnt_eff;

  assign win_diff  = cur_r.offset - head_r;
  assign in_window = (win_diff < OFF_W'(DEPTH));
  assign avail     = tail_r - head_r;
  assign over      = (OFF_W'(cur_r.count) > avail);
  assign cnt_eff   = over ? avail[CNT_W-1:0] : cur_r.count;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cnt_nxt    = cnt_r;
    clr_nxt    = clr_r;
    clamp_nxt  = clamp_r;
    cur_nxt    = cur_r;
    finish     = 1'b0;
    res_status = ST_OK;
    res_rdata  = '0;
    mem_we     = 1'b0;
    mem_addr   = cur_r.slot;
    mem_wdata  = '0;
    deq_pop    = 1'b0;

    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == SLOT_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        // The result slot is free by the time this command can finish.
        if (deq_valid && (!out_valid_r || out_ready)) begin
          deq_pop   = 1'b1;
          cur_nxt   = deq_cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cur_r.op)
          ACT_WRITE: begin
            finish = 1'b1;
            if (in_window) begin
              mem_we     = 1'b1;
              mem_wdata  = {1'b1, cur_r.data};
              res_status = cur_r.last ? ST_PKT_DONE : ST_OK;
            end else begin
              res_status = ST_DROP;
            end
          end
          ACT_READ: begin
            if (in_window) begin
              state_nxt = S_RD_WAIT;
            end else begin
              finish     = 1'b1;
              res_status = ST_DROP;
            end
          end
          ACT_QUERY: begin
            state_nxt = S_Q_CHK;
          end
          ACT_RELEASE: begin
            if (cnt_eff == '0) begin
              finish     = 1'b1;
              res_status = over ? ST_CLAMP : ST_OK;
            end else begin
              cnt_nxt   = cnt_eff;
              clamp_nxt = over;
              state_nxt = S_REL;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      S_RD_WAIT: begin
        finish    = 1'b1;
        res_rdata = mem_rd_r[DATA_W] ? mem_rd_r[DATA_W-1:0] : '0;
      end
      S_Q_CHK: begin
        if (avail < OFF_W'(DEPTH)) begin
          mem_addr  = slot_of(tail_r);
          state_nxt = S_Q_WAIT;
        end else begin
          finish = 1'b1;
        end
      end
      S_Q_WAIT: begin
        if (mem_rd_r[DATA_W]) begin
          tail_nxt  = tail_r + 1'b1;
          state_nxt = S_Q_CHK;
        end else begin
          finish = 1'b1;
        end
      end
      S_REL: begin
        mem_we   = 1'b1;
        mem_addr = slot_of(head_r);
        head_nxt = head_r + 1'b1;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          finish     = 1'b1;
          res_status = clamp_r ? ST_CLAMP : ST_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (finish) begin
      state_nxt = S_IDLE;
    end

    run_diff                    = tail_nxt - head_nxt;
    out_data_nxt                = out_data_r;
    out_valid_nxt               = out_valid_r && !out_ready;
    if (finish) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.head_offset    = head_nxt;
      out_data_nxt.contiguous_len = (run_diff > OFF_W'(LEN_SAT)) ? LEN_W'(LEN_SAT)
                                                                 : run_diff[LEN_W-1:0];
      out_data_nxt.read_data      = res_rdata;
      out_data_nxt.status         = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= '0;
      tail_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r      <= cnt_nxt;
    clamp_r    <= clamp_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_mem[mem_addr] <= mem_wdata;
    end
    mem_rd_r <= byte_mem[mem_addr];
  end

endmodule
`default_nettype wire

// ----- design/srb_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module srb_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire srb_pkg::out_item_t out_data
);
  import srb_pkg::*;

  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "stalled result changed")
  `ASSERT_ALWAYS(a_rdata_ok, !out_valid || out_data.read_data == '0 || out_data.status == ST_OK, "read data with bad status")
  `ASSERT_ALWAYS(a_len_cap, !out_valid || out_data.contiguous_len <= LEN_W'(LEN_CAP), "run length beyond ring")

endmodule

bind stream_reorder_buffer srb_checker u_srb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
